FILE: rtl/tmre_pkg.sv
// Shared types and constants for the tile map row expander.
package tmre_pkg;

    localparam int ACTION_W     = 2;
    localparam int CELL_W       = 5;
    localparam int TILE_W       = 2;
    localparam int GLYPH_IDX_W  = 6;
    localparam int CODE_W       = 8;
    localparam int SCROLL_W     = 7;
    localparam int ROW_W        = 6;
    localparam int COL_W        = 6;
    localparam int GLYPH_DEPTH  = 64;

    // Output queue depth and its fill count width
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = 2;
    localparam int OUT_CNT_W    = 3;

    localparam logic [ACTION_W-1:0] ACTION_MAP_WRITE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_GLYPH_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_RENDER      = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0]  screen_column;
        logic [CODE_W-1:0] char_code;
        logic              last;
    } result_t;

endpackage

FILE: rtl/tmre_out_fifo.sv
// Small result queue between the render pipeline and the output port.
module tmre_out_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push_valid,
    input  tmre_pkg::result_t               push_item,
    input  logic                            pop_ready,
    output logic                            pop_valid,
    output tmre_pkg::result_t               pop_item,
    output logic [tmre_pkg::OUT_CNT_W-1:0]  fill_count
);

    tmre_pkg::result_t                    slot_reg [tmre_pkg::OUT_DEPTH];
    logic [tmre_pkg::OUT_PTR_W-1:0]       wr_ptr_reg;
    logic [tmre_pkg::OUT_PTR_W-1:0]       rd_ptr_reg;
    logic [tmre_pkg::OUT_CNT_W-1:0]       count_reg;
    logic                                 pop;

    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign fill_count = count_reg;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push_valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/tile_map_row_expander_unit.sv
// Top level of the tile map row expander: map and glyph memories, render pipeline.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_action .. s_screen_row | in
//   result  | m_valid m_ready m_screen_column ..       | out
//
// Map and glyph write items emit nothing.
// A render item emits SCREEN_COLUMNS items, at best one per cycle as credits allow;
// the bound is the single read port of each memory.
// Input is not taken while a row is still being issued into the pipeline.
// A stalled result side holds issue back through credits on a 4-deep queue.
// Reset clears control only; memory contents are undefined until written.
module tile_map_row_expander_unit #(
    parameter int MAP_SIDE       = 32,
    parameter int SCREEN_COLUMNS = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tmre_pkg::ACTION_W-1:0]       s_action,
    input  logic [tmre_pkg::CELL_W-1:0]         s_cell_x,
    input  logic [tmre_pkg::CELL_W-1:0]         s_cell_y,
    input  logic [tmre_pkg::TILE_W-1:0]         s_tile_number,
    input  logic [tmre_pkg::GLYPH_IDX_W-1:0]    s_glyph_index,
    input  logic [tmre_pkg::CODE_W-1:0]         s_glyph_code,
    input  logic [tmre_pkg::SCROLL_W-1:0]       s_scroll_x,
    input  logic [tmre_pkg::SCROLL_W-1:0]       s_scroll_y,
    input  logic [tmre_pkg::ROW_W-1:0]          s_screen_row,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmre_pkg::COL_W-1:0]          m_screen_column,
    output logic [tmre_pkg::CODE_W-1:0]         m_char_code,
    output logic                                m_last
);

    localparam int MAP_AW = $clog2(MAP_SIDE);
    localparam int MAP_IW = $clog2(MAP_SIDE * MAP_SIDE);

    // Reduce a small tile coordinate (at most 47) modulo the map side.
    function automatic logic [MAP_AW-1:0] side_mod(input logic [5:0] v);
        int r;
        r = int'(v);
        for (int i = 0; i < 6; i++) begin
            if (r >= MAP_SIDE) begin
                r = r - MAP_SIDE;
            end
        end
        return MAP_AW'(r);
    endfunction

    function automatic logic [MAP_IW-1:0] map_addr(input logic [MAP_AW-1:0] row,
                                                   input logic [MAP_AW-1:0] col);
        return MAP_IW'(row) * MAP_IW'(MAP_SIDE) + MAP_IW'(col);
    endfunction

    // Storage
    logic [tmre_pkg::TILE_W-1:0] tile_map_mem [MAP_SIDE * MAP_SIDE];
    logic [tmre_pkg::CODE_W-1:0] glyph_mem    [tmre_pkg::GLYPH_DEPTH];

    // Row sequencer
    logic                          busy_reg;
    logic [tmre_pkg::COL_W-1:0]    col_reg;
    logic [MAP_AW-1:0]             map_row_reg;
    logic [MAP_AW-1:0]             map_col_reg;
    logic [1:0]                    x_lo_reg;
    logic [1:0]                    y_lo_reg;

    // Stage A: map read in flight
    logic                          a_valid_reg;
    logic [tmre_pkg::COL_W-1:0]    a_col_reg;
    logic                          a_last_reg;
    logic [1:0]                    a_xlo_reg;
    logic [tmre_pkg::TILE_W-1:0]   map_rd_reg;

    // Stage B: glyph read in flight
    logic                          b_valid_reg;
    logic [tmre_pkg::COL_W-1:0]    b_col_reg;
    logic                          b_last_reg;
    logic [tmre_pkg::CODE_W-1:0]   glyph_rd_reg;

    logic                              accept;
    logic                              issue;
    logic                              issue_last;
    logic [tmre_pkg::OUT_CNT_W:0]      credits_used;
    logic [tmre_pkg::OUT_CNT_W-1:0]    fill_count;
    logic [7:0]                        y_sum;
    logic [tmre_pkg::GLYPH_IDX_W-1:0]  glyph_rd_idx;
    tmre_pkg::result_t                 push_item;
    tmre_pkg::result_t                 pop_item;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign y_sum   = {1'b0, s_scroll_y} + {2'b00, s_screen_row};

    // Queue slots already claimed by stored results and items in flight
    assign credits_used = {1'b0, fill_count}
                        + (tmre_pkg::OUT_CNT_W+1)'(a_valid_reg)
                        + (tmre_pkg::OUT_CNT_W+1)'(b_valid_reg);
    assign issue      = busy_reg &&
                        (credits_used < (tmre_pkg::OUT_CNT_W+1)'(tmre_pkg::OUT_DEPTH));
    assign issue_last = (col_reg == tmre_pkg::COL_W'(SCREEN_COLUMNS - 1));

    assign glyph_rd_idx = {a_xlo_reg, y_lo_reg, map_rd_reg};

    // Map memory: single port, writes only come in while idle
    always_ff @(posedge aclk) begin
        if (accept && (s_action == tmre_pkg::ACTION_MAP_WRITE)) begin
            tile_map_mem[map_addr(side_mod({1'b0, s_cell_y}),
                                  side_mod({1'b0, s_cell_x}))] <= s_tile_number;
        end
        if (issue) begin
            map_rd_reg <= tile_map_mem[map_addr(map_row_reg, map_col_reg)];
        end
    end

    // Glyph memory: a write after a row's last issue lands after that column's read
    always_ff @(posedge aclk) begin
        if (accept && (s_action == tmre_pkg::ACTION_GLYPH_WRITE)) begin
            glyph_mem[s_glyph_index] <= s_glyph_code;
        end
        if (a_valid_reg) begin
            glyph_rd_reg <= glyph_mem[glyph_rd_idx];
        end
    end

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept && (s_action == tmre_pkg::ACTION_RENDER)) begin
                busy_reg <= 1'b1;
            end else if (issue && issue_last) begin
                busy_reg <= 1'b0;
            end
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Sequencer and pipeline payload
    always_ff @(posedge aclk) begin
        if (accept && (s_action == tmre_pkg::ACTION_RENDER)) begin
            col_reg     <= '0;
            map_row_reg <= side_mod(y_sum[7:2]);
            y_lo_reg    <= y_sum[1:0];
            map_col_reg <= side_mod({1'b0, s_scroll_x[6:2]});
            x_lo_reg    <= s_scroll_x[1:0];
        end else if (issue) begin
            col_reg  <= col_reg + 1'b1;
            x_lo_reg <= x_lo_reg + 1'b1;
            if (x_lo_reg == 2'd3) begin
                // tile columns wrap around the map, no carry into the next row
                if (map_col_reg == MAP_AW'(MAP_SIDE - 1)) begin
                    map_col_reg <= '0;
                end else begin
                    map_col_reg <= map_col_reg + 1'b1;
                end
            end
        end
        if (issue) begin
            a_col_reg  <= col_reg;
            a_last_reg <= issue_last;
            a_xlo_reg  <= x_lo_reg;
        end
        if (a_valid_reg) begin
            b_col_reg  <= a_col_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign push_item.screen_column = b_col_reg;
    assign push_item.char_code     = glyph_rd_reg;
    assign push_item.last          = b_last_reg;

    tmre_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (b_valid_reg),
        .push_item  (push_item),
        .pop_ready  (m_ready),
        .pop_valid  (m_valid),
        .pop_item   (pop_item),
        .fill_count (fill_count)
    );

    assign m_screen_column = pop_item.screen_column;
    assign m_char_code     = pop_item.char_code;
    assign m_last          = pop_item.last;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credits_used <= (tmre_pkg::OUT_CNT_W+1)'(tmre_pkg::OUT_DEPTH))
        else $error("result queue overcommitted");

    a_render_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == tmre_pkg::ACTION_RENDER)) |=> busy_reg)
        else $error("render item did not start a row");

    a_issue_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> $past(busy_reg))
        else $error("map read issued outside a row");

    a_stage_order: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> $past(a_valid_reg))
        else $error("glyph stage without a map read before it");

    a_last_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && issue_last) |=> !busy_reg)
        else $error("row kept running after its last column");
`endif

endmodule

FILE: bench/tb_tile_map_row_expander_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tile map row expander: directed plan, then random traffic.
module tb_tile_map_row_expander_unit;

    // Block geometry at its default parameters. With a 32-cell map the map
    // row and column are bits [6:2] of the character coordinate.
    localparam int SCREEN_COLS  = 40;
    localparam int MAP_CELLS    = 1024;
    // Working items in the random phase, fill writes included; the directed
    // plan with its fills already brings about a hundred.
    localparam int RANDOM_ITEMS = 20;
    localparam int PLAN_ROWS    = 18;
    // Slowest honest run: every item gapped and every character of the
    // 40-character renders stalled by the longest wait. The limit allows
    // several times that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;

    // The action code with no function; the block drops it silently.
    localparam logic [tmre_pkg::ACTION_W-1:0] ACTION_UNUSED = 2'd3;

    // Short names for the action codes in the plan table
    localparam logic [tmre_pkg::ACTION_W-1:0] ACT_MAP    = tmre_pkg::ACTION_MAP_WRITE;
    localparam logic [tmre_pkg::ACTION_W-1:0] ACT_GLYPH  = tmre_pkg::ACTION_GLYPH_WRITE;
    localparam logic [tmre_pkg::ACTION_W-1:0] ACT_RENDER = tmre_pkg::ACTION_RENDER;

    typedef struct packed {
        logic [tmre_pkg::ACTION_W-1:0]    action;
        logic [tmre_pkg::CELL_W-1:0]      cell_x;
        logic [tmre_pkg::CELL_W-1:0]      cell_y;
        logic [tmre_pkg::TILE_W-1:0]      tile;
        logic [tmre_pkg::GLYPH_IDX_W-1:0] glyph_index;
        logic [tmre_pkg::CODE_W-1:0]      glyph_code;
        logic [tmre_pkg::SCROLL_W-1:0]    scroll_x;
        logic [tmre_pkg::SCROLL_W-1:0]    scroll_y;
        logic [tmre_pkg::ROW_W-1:0]       screen_row;
    } item_t;

    // One directed step. When uniform is set the render is preceded by fills
    // of fill_tile / fill_code into every unwritten entry it reads, so each of its
    // characters must come back as fill_code.
    typedef struct packed {
        item_t                       it;
        logic                        uniform;
        logic [tmre_pkg::TILE_W-1:0] fill_tile;
        logic [tmre_pkg::CODE_W-1:0] fill_code;
    } plan_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic [tmre_pkg::ACTION_W-1:0]    s_action      = '0;
    logic [tmre_pkg::CELL_W-1:0]      s_cell_x      = '0;
    logic [tmre_pkg::CELL_W-1:0]      s_cell_y      = '0;
    logic [tmre_pkg::TILE_W-1:0]      s_tile_number = '0;
    logic [tmre_pkg::GLYPH_IDX_W-1:0] s_glyph_index = '0;
    logic [tmre_pkg::CODE_W-1:0]      s_glyph_code  = '0;
    logic [tmre_pkg::SCROLL_W-1:0]    s_scroll_x    = '0;
    logic [tmre_pkg::SCROLL_W-1:0]    s_scroll_y    = '0;
    logic [tmre_pkg::ROW_W-1:0]       s_screen_row  = '0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic [tmre_pkg::COL_W-1:0]       m_screen_column;
    logic [tmre_pkg::CODE_W-1:0]      m_char_code;
    logic                             m_last;

    // Mirror of the block's memories plus written flags, so that no render
    // is ever sent that would read an entry never written.
    logic [tmre_pkg::TILE_W-1:0] map_mirror   [0:MAP_CELLS-1];
    bit                          map_known    [0:MAP_CELLS-1];
    logic [tmre_pkg::CODE_W-1:0] glyph_mirror [0:tmre_pkg::GLYPH_DEPTH-1];
    bit                          glyph_known  [0:tmre_pkg::GLYPH_DEPTH-1];

    // Characters predicted but not yet seen on the result side, oldest first.
    tmre_pkg::result_t expected_chars [$];

    plan_row_t plan [PLAN_ROWS];

    bit calm = 1'b0;          // stretch with no idling on either side
    int fed_items     = 0;    // accepted items that do something
    int rows_rendered = 0;
    int unused_sent   = 0;
    int chars_checked = 0;
    int fail_count    = 0;
    int cycles        = 0;

    tile_map_row_expander_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_cell_x        (s_cell_x),
        .s_cell_y        (s_cell_y),
        .s_tile_number   (s_tile_number),
        .s_glyph_index   (s_glyph_index),
        .s_glyph_code    (s_glyph_code),
        .s_scroll_x      (s_scroll_x),
        .s_scroll_y      (s_scroll_y),
        .s_screen_row    (s_screen_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_screen_column (m_screen_column),
        .m_char_code     (m_char_code),
        .m_last          (m_last)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost character ends here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Per-item random wait on either side, none during a calm stretch.
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic plan_row_t plan_step(input int action, input int cx, input int cy,
                                            input int tile, input int gidx, input int gcode,
                                            input int sx, input int sy, input int row,
                                            input bit uniform, input int ftile,
                                            input int fcode);
        plan_row_t p;
        p.it.action      = tmre_pkg::ACTION_W'(action);
        p.it.cell_x      = tmre_pkg::CELL_W'(cx);
        p.it.cell_y      = tmre_pkg::CELL_W'(cy);
        p.it.tile        = tmre_pkg::TILE_W'(tile);
        p.it.glyph_index = tmre_pkg::GLYPH_IDX_W'(gidx);
        p.it.glyph_code  = tmre_pkg::CODE_W'(gcode);
        p.it.scroll_x    = tmre_pkg::SCROLL_W'(sx);
        p.it.scroll_y    = tmre_pkg::SCROLL_W'(sy);
        p.it.screen_row  = tmre_pkg::ROW_W'(row);
        p.uniform        = uniform;
        p.fill_tile      = tmre_pkg::TILE_W'(ftile);
        p.fill_code      = tmre_pkg::CODE_W'(fcode);
        return p;
    endfunction

    // Random item: every field fully random, the action weighted toward
    // renders and writes. Fields an action does not use are noise.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick           = $urandom_range(0, 99);
        it.action      = (pick < 35) ? tmre_pkg::ACTION_MAP_WRITE :
                         (pick < 60) ? tmre_pkg::ACTION_GLYPH_WRITE :
                         (pick < 92) ? tmre_pkg::ACTION_RENDER : ACTION_UNUSED;
        it.cell_x      = tmre_pkg::CELL_W'($urandom);
        it.cell_y      = tmre_pkg::CELL_W'($urandom);
        it.tile        = tmre_pkg::TILE_W'($urandom);
        it.glyph_index = tmre_pkg::GLYPH_IDX_W'($urandom);
        it.glyph_code  = tmre_pkg::CODE_W'($urandom);
        it.scroll_x    = tmre_pkg::SCROLL_W'($urandom);
        it.scroll_y    = tmre_pkg::SCROLL_W'($urandom);
        it.screen_row  = tmre_pkg::ROW_W'($urandom);
        return it;
    endfunction

    // Predictor: applies an accepted item to the mirror and, for a render,
    // queues the forty characters of the row. A uniform render queues its
    // typed-in code instead of looking it up.
    task automatic mirror_and_expand(input item_t it, input bit uniform,
                                     input logic [tmre_pkg::CODE_W-1:0] fill_code);
        logic [7:0]                       y;
        logic [7:0]                       x;
        logic [4:0]                       map_row;
        logic [tmre_pkg::TILE_W-1:0]      t;
        logic [tmre_pkg::GLYPH_IDX_W-1:0] g;
        tmre_pkg::result_t                r;
        case (it.action)
            tmre_pkg::ACTION_MAP_WRITE: begin
                map_mirror[{it.cell_y, it.cell_x}] = it.tile;
                map_known[{it.cell_y, it.cell_x}]  = 1'b1;
            end
            tmre_pkg::ACTION_GLYPH_WRITE: begin
                glyph_mirror[it.glyph_index] = it.glyph_code;
                glyph_known[it.glyph_index]  = 1'b1;
            end
            tmre_pkg::ACTION_RENDER: begin
                y       = {1'b0, it.scroll_y} + {2'b00, it.screen_row};
                map_row = y[6:2];
                for (int c = 0; c < SCREEN_COLS; c++) begin
                    // tile columns wrap within the same map row
                    x = 8'(int'(it.scroll_x) + c);
                    t = map_mirror[{map_row, x[6:2]}];
                    g = {x[1:0], y[1:0], t};
                    r.screen_column = tmre_pkg::COL_W'(c);
                    r.char_code     = uniform ? fill_code : glyph_mirror[g];
                    r.last          = (c == SCREEN_COLS - 1);
                    expected_chars.push_back(r);
                end
                rows_rendered++;
            end
            default: ;
        endcase
    endtask

    // Present one item and hold it until accepted. The gap before it, if
    // any, is the only place valid drops, so valid never falls and rises
    // in one step.
    task automatic send_item(input item_t it, input bit uniform,
                             input logic [tmre_pkg::CODE_W-1:0] fill_code);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= it.action;
        s_cell_x      <= it.cell_x;
        s_cell_y      <= it.cell_y;
        s_tile_number <= it.tile;
        s_glyph_index <= it.glyph_index;
        s_glyph_code  <= it.glyph_code;
        s_scroll_x    <= it.scroll_x;
        s_scroll_y    <= it.scroll_y;
        s_screen_row  <= it.screen_row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror_and_expand(it, uniform, fill_code);
        if (it.action == ACTION_UNUSED)
            unused_sent++;
        else
            fed_items++;
    endtask

    // Before a render, write every map cell and glyph entry it will read
    // that was never written. Fixed fills make a uniform row; otherwise
    // the written values are random.
    task automatic cover_row_reads(input item_t rend, input bit fixed,
                                   input logic [tmre_pkg::TILE_W-1:0] fill_tile,
                                   input logic [tmre_pkg::CODE_W-1:0] fill_code);
        item_t                            w;
        logic [7:0]                       y;
        logic [7:0]                       x;
        logic [tmre_pkg::GLYPH_IDX_W-1:0] g;
        y = {1'b0, rend.scroll_y} + {2'b00, rend.screen_row};
        for (int c = 0; c < SCREEN_COLS; c++) begin
            x = 8'(int'(rend.scroll_x) + c);
            if (!map_known[{y[6:2], x[6:2]}]) begin
                w        = random_item();
                w.action = tmre_pkg::ACTION_MAP_WRITE;
                w.cell_y = y[6:2];
                w.cell_x = x[6:2];
                if (fixed)
                    w.tile = fill_tile;
                send_item(w, 1'b0, '0);
            end
            g = {x[1:0], y[1:0], map_mirror[{y[6:2], x[6:2]}]};
            if (!glyph_known[g]) begin
                w             = random_item();
                w.action      = tmre_pkg::ACTION_GLYPH_WRITE;
                w.glyph_index = g;
                if (fixed)
                    w.glyph_code = fill_code;
                send_item(w, 1'b0, '0);
            end
        end
    endtask

    // Stop feeding until every predicted character has come out.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
    endtask

    // Result side: a fresh stall before each character, then ready held
    // until one is taken.
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Every character taken is compared with the oldest prediction.
    always @(posedge aclk) begin : check_chars
        tmre_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected char: col %0d code %02h last %0b",
                             $realtime, m_screen_column, m_char_code, m_last);
            end else begin
                want = expected_chars.pop_front();
                if (m_screen_column !== want.screen_column ||
                    m_char_code !== want.char_code || m_last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: want col %0d code %02h last %0b, got %0d %02h %0b",
                                 $realtime, want.screen_column, want.char_code, want.last,
                                 m_screen_column, m_char_code, m_last);
                end
            end
        end
    end

    initial begin : stimulus
        item_t it;
        int    fed_before;
        int    n;

        // Directed plan. Uniform renders come first, while every entry they
        // read is still fresh and so takes the fill value.
        //                     action          cx  cy  t  gidx gcode  sx   sy   row  uni ft fc
        plan[0]  = plan_step(ACTION_UNUSED,  31, 31, 3, 63, 8'hff, 127, 127, 63, 0, 0, 0);
        plan[1]  = plan_step(ACT_RENDER,      0,  0, 0,  0, 8'h00,   0,   0,  0, 1, 2, 8'h55);
        // both scrolls and the row at their maximum, tile columns wrap
        plan[2]  = plan_step(ACT_RENDER,      5,  9, 1, 17, 8'h20, 127, 127, 63, 1, 1, 8'he1);
        plan[3]  = plan_step(ACT_GLYPH,       0,  0, 0,  0, 8'h00,   0,   0,  0, 0, 0, 0);
        plan[4]  = plan_step(ACT_GLYPH,      31, 31, 3, 63, 8'hff, 127, 127, 63, 0, 0, 0);
        plan[5]  = plan_step(ACT_MAP,         0,  0, 3,  0, 8'h00,   0,   0,  0, 0, 0, 0);
        plan[6]  = plan_step(ACT_MAP,        31, 31, 0, 63, 8'hff, 127, 127, 63, 0, 0, 0);
        plan[7]  = plan_step(ACT_MAP,        31,  0, 1, 12, 8'h65,  64,   3, 32, 0, 0, 0);
        plan[8]  = plan_step(ACT_GLYPH,       4,  7, 2, 18, 8'h6c,  10,  20, 30, 0, 0, 0);
        // same row again, now over a mixed map
        plan[9]  = plan_step(ACT_RENDER,      0,  0, 0,  0, 8'h00,   0,   0,  0, 0, 0, 0);
        // right edge: tile column 31 followed by column 0 of the same map row
        plan[10] = plan_step(ACT_RENDER,      1,  2, 3, 33, 8'ha0, 124,   0,  3, 0, 0, 0);
        plan[11] = plan_step(ACT_RENDER,     16, 16, 2, 40, 8'h40, 100,  64, 63, 0, 0, 0);
        plan[12] = plan_step(ACTION_UNUSED,   0,  0, 0,  0, 8'h00,   0,   0,  0, 0, 0, 0);
        plan[13] = plan_step(ACT_MAP,        21, 10, 2,  7, 8'h62,  33,  66, 11, 0, 0, 0);
        plan[14] = plan_step(ACT_GLYPH,      12, 19, 1, 42, 8'h4e,  90,  45,  5, 0, 0, 0);
        plan[15] = plan_step(ACT_RENDER,      9,  3, 0, 50, 8'h77,  85,  40,  1, 0, 0, 0);
        plan[16] = plan_step(ACT_GLYPH,      27, 14, 3, 21, 8'h5d,  71,  99, 44, 0, 0, 0);
        plan[17] = plan_step(ACT_RENDER,      2, 30, 1, 29, 8'h6f, 127, 124,  0, 0, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].it.action == tmre_pkg::ACTION_RENDER)
                cover_row_reads(plan[i].it, plan[i].uniform, plan[i].fill_tile,
                                plan[i].fill_code);
            send_item(plan[i].it, plan[i].uniform, plan[i].fill_code);
        end

        // Let the block run dry once before random traffic starts.
        hold_until_drained();

        // Random traffic. Calm stretches come and go; now and then the
        // sender waits for the block to empty.
        fed_before = fed_items;
        n          = 0;
        while (fed_items - fed_before < RANDOM_ITEMS) begin
            if (n % 12 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 14) == 0)
                hold_until_drained();
            it = random_item();
            if (it.action == tmre_pkg::ACTION_RENDER)
                cover_row_reads(it, 1'b0, '0, '0);
            send_item(it, 1'b0, '0);
            n++;
        end

        hold_until_drained();
        // A stray character after the last prediction would show up here.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run fed %0d working items and %0d unused-action items, rendered %0d rows.",
                 fed_items, unused_sent, rows_rendered);
        $display("Checked %0d characters in %0d cycles, %0d bad.",
                 chars_checked, cycles, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tmre_pkg.sv
rtl/tmre_out_fifo.sv
rtl/tile_map_row_expander_unit.sv
bench/tb_tile_map_row_expander_unit.sv
